FILE: sv/qti_pkg.sv
// Package for the QPP turbo interleaver: request/response types, register
// indexes, sequencer states, size list decoding and the f1/f2 coefficient ROM.
// No dependencies.
package qti_pkg;

  localparam int MAX_BLOCK = 6144;
  localparam int NUM_SIZES = 188;
  localparam int DIV_STEPS = 27;

  localparam logic CFG_BLOCK_SIZE  = 1'b0;
  localparam logic CFG_WINDOW_SIZE = 1'b1;

  localparam logic FUNC_BUILD = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [12:0] index;
  } in_req_t;

  typedef struct packed {
    logic [12:0] forward_index;
    logic [12:0] reverse_index;
    logic        status;
  } out_rsp_t;

  typedef struct packed {
    logic func;
    logic oob;
  } stage_ctl_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] slot;
  } slot_t;

  typedef enum logic [2:0] {
    SEQ_LOAD,
    SEQ_DIV_Q,
    SEQ_DIV_MW,
    SEQ_DIV_MQ,
    SEQ_DIV_MK,
    SEQ_IDLE
  } seq_state_e;

  localparam logic [8:0] F1_ROM [NUM_SIZES] = '{
    9'd3,   9'd7,   9'd19,  9'd7,   9'd7,   9'd11,  9'd5,   9'd11,  9'd7,   9'd41,  9'd103,
    9'd15,  9'd9,   9'd17,  9'd9,   9'd21,  9'd101, 9'd21,  9'd57,  9'd23,  9'd13,
    9'd27,  9'd11,  9'd27,  9'd85,  9'd29,  9'd33,  9'd15,  9'd17,  9'd33,  9'd103,
    9'd19,  9'd19,  9'd37,  9'd19,  9'd21,  9'd21,  9'd115, 9'd193, 9'd21,  9'd133, 9'd81,
    9'd45,  9'd23,  9'd243, 9'd151, 9'd155, 9'd25,  9'd51,  9'd47,  9'd91,  9'd29,
    9'd29,  9'd247, 9'd29,  9'd89,  9'd91,  9'd157, 9'd55,  9'd31,  9'd17,  9'd35,  9'd227,
    9'd65,  9'd19,  9'd37,  9'd41,  9'd39,  9'd185, 9'd43,  9'd21,  9'd155, 9'd79,
    9'd139, 9'd23,  9'd217, 9'd25,  9'd17,  9'd127, 9'd25,  9'd239, 9'd17,  9'd137, 9'd215,
    9'd29,  9'd15,  9'd147, 9'd29,  9'd59,  9'd65,  9'd55,  9'd31,  9'd17,  9'd171,
    9'd67,  9'd35,  9'd19,  9'd39,  9'd19,  9'd199, 9'd21,  9'd211, 9'd21,  9'd43,  9'd149,
    9'd45,  9'd49,  9'd71,  9'd13,  9'd17,  9'd25,  9'd183, 9'd55,  9'd127, 9'd27,
    9'd29,  9'd29,  9'd57,  9'd45,  9'd31,  9'd59,  9'd185, 9'd113, 9'd31,  9'd17,  9'd171,
    9'd209, 9'd253, 9'd367, 9'd265, 9'd181, 9'd39,  9'd27,  9'd127, 9'd143, 9'd43,
    9'd29,  9'd45,  9'd157, 9'd47,  9'd13,  9'd111, 9'd443, 9'd51,  9'd51,  9'd451, 9'd257,
    9'd57,  9'd313, 9'd271, 9'd179, 9'd331, 9'd363, 9'd375, 9'd127, 9'd31,  9'd33,
    9'd43,  9'd33,  9'd477, 9'd35,  9'd233, 9'd357, 9'd337, 9'd37,  9'd71,  9'd71,  9'd37,
    9'd39,  9'd127, 9'd39,  9'd39,  9'd31,  9'd113, 9'd41,  9'd251, 9'd43,  9'd21,
    9'd43,  9'd45,  9'd45,  9'd161, 9'd89,  9'd323, 9'd47,  9'd23,  9'd47,  9'd263
  };

  localparam logic [9:0] F2_ROM [NUM_SIZES] = '{
    10'd10,  10'd12,  10'd42,  10'd16,  10'd18,  10'd20,  10'd22,  10'd24,  10'd26,
    10'd84,  10'd90,  10'd32,  10'd34,  10'd108, 10'd38,  10'd120, 10'd84,  10'd44,
    10'd46,  10'd48,  10'd50,
    10'd52,  10'd36,  10'd56,  10'd58,  10'd60,  10'd62,  10'd32,  10'd198, 10'd68,
    10'd210, 10'd36,  10'd74,  10'd76,  10'd78,  10'd120, 10'd82,  10'd84,  10'd86,
    10'd44,  10'd90,  10'd46,
    10'd94,  10'd48,  10'd98,  10'd40,  10'd102, 10'd52,  10'd106, 10'd72,  10'd110,
    10'd168, 10'd114, 10'd58,  10'd118, 10'd180, 10'd122, 10'd62,  10'd84,  10'd64,
    10'd66,  10'd68,  10'd420,
    10'd96,  10'd74,  10'd76,  10'd234, 10'd80,  10'd82,  10'd252, 10'd86,  10'd44,
    10'd120, 10'd92,  10'd94,  10'd48,  10'd98,  10'd80,  10'd102, 10'd52,  10'd106,
    10'd48,  10'd110, 10'd112,
    10'd114, 10'd58,  10'd118, 10'd60,  10'd122, 10'd124, 10'd84,  10'd64,  10'd66,
    10'd204, 10'd140, 10'd72,  10'd74,  10'd76,  10'd78,  10'd240, 10'd82,  10'd252,
    10'd86,  10'd88,  10'd60,
    10'd92,  10'd846, 10'd48,  10'd28,  10'd80,  10'd102, 10'd104, 10'd954, 10'd96,
    10'd110, 10'd112, 10'd114, 10'd116, 10'd354, 10'd120, 10'd610, 10'd124, 10'd420,
    10'd64,  10'd66,  10'd136,
    10'd420, 10'd216, 10'd444, 10'd456, 10'd468, 10'd80,  10'd164, 10'd504, 10'd172,
    10'd88,  10'd300, 10'd92,  10'd188, 10'd96,  10'd28,  10'd240, 10'd204, 10'd104,
    10'd212, 10'd192, 10'd220,
    10'd336, 10'd228, 10'd232, 10'd236, 10'd120, 10'd244, 10'd248, 10'd168, 10'd64,
    10'd130, 10'd264, 10'd134, 10'd408, 10'd138, 10'd280, 10'd142, 10'd480, 10'd146,
    10'd444, 10'd120, 10'd152,
    10'd462, 10'd234, 10'd158, 10'd80,  10'd96,  10'd902, 10'd166, 10'd336, 10'd170,
    10'd86,  10'd174, 10'd176, 10'd178, 10'd120, 10'd182, 10'd184, 10'd186, 10'd94,
    10'd190, 10'd480
  };

  // Position of K in the LTE code block size list.
  function automatic slot_t size_slot(logic [12:0] k);
    slot_t       s;
    logic [12:0] d;
    s.ok   = 1'b0;
    s.slot = '0;
    d      = '0;
    if (k < 13'd40 || k > 13'(MAX_BLOCK)) begin
      s.ok = 1'b0;
    end else if (k <= 13'd512) begin
      d      = k - 13'd40;
      s.ok   = (k[2:0] == 3'd0);
      s.slot = d[10:3];
    end else if (k <= 13'd1024) begin
      d      = k - 13'd512;
      s.ok   = (k[3:0] == 4'd0);
      s.slot = 8'd59 + d[11:4];
    end else if (k <= 13'd2048) begin
      d      = k - 13'd1024;
      s.ok   = (k[4:0] == 5'd0);
      s.slot = 8'd91 + d[12:5];
    end else begin
      d      = k - 13'd2048;
      s.ok   = (k[5:0] == 6'd0);
      s.slot = 8'd123 + {1'b0, d[12:6]};
    end
    return s;
  endfunction

endpackage

FILE: sv/qpp_turbo_interleaver.sv
// One request per cycle while in_stall_o is low; output back-pressure also stalls input.
// A read request waits while build requests are still in the pipeline.
// After reset and after each config write a serial divider derives q = K/w and the
// reciprocals of w, q and K: input stalls until its four 27-step divides are done.
// Reset clears control and sets K=40, w=1; table memories are not cleared.
// Uses qti_pkg and qti_ram.
module qpp_turbo_interleaver (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [12:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  qti_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output qti_pkg::out_rsp_t out_rsp_o
);

  // configuration and derived constants
  logic [12:0] block_size_q;
  logic [6:0]  window_size_q;
  logic [6:0]  weff_d, weff_q;
  logic [8:0]  f1_q;
  logic [9:0]  f2_q;
  logic        bad_q;
  logic [12:0] q_q;
  logic [13:0] mw_q, mq_q;
  logic [20:0] mk_q;
  logic [17:0] mk23;
  qti_pkg::slot_t slot;

  // sequencer and serial divider
  qti_pkg::seq_state_e state_q, state_d;
  logic [4:0]  cnt_q;
  logic [12:0] rem_q, dvs_q;
  logic [26:0] dq_q;
  logic [13:0] div_t, div_diff;
  logic        div_ge, div_run, div_load, div_done;
  logic [12:0] rem_step;
  logic [26:0] dq_step;
  logic [26:0] div_dividend;
  logic [12:0] div_divisor;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q  <= 13'd40;
      window_size_q <= 7'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qti_pkg::CFG_BLOCK_SIZE:  block_size_q  <= cfg_data_i;
        qti_pkg::CFG_WINDOW_SIZE: window_size_q <= cfg_data_i[6:0];
        default:                  block_size_q  <= block_size_q;
      endcase
    end
  end

  assign slot   = qti_pkg::size_slot(block_size_q);
  assign weff_d = (window_size_q == 7'd0 || {6'b0, window_size_q} > block_size_q) ?
                  7'd1 : window_size_q;
  assign mk23   = mk_q[20:3];

  assign div_t    = {rem_q, dq_q[26]};
  assign div_diff = div_t - {1'b0, dvs_q};
  assign div_ge   = (div_t >= {1'b0, dvs_q});
  assign rem_step = div_ge ? div_diff[12:0] : div_t[12:0];
  assign dq_step  = {dq_q[25:0], div_ge};

  always_comb begin
    state_d = state_q;
    case (state_q)
      qti_pkg::SEQ_LOAD:   state_d = qti_pkg::SEQ_DIV_Q;
      qti_pkg::SEQ_DIV_Q:  if (div_done) state_d = qti_pkg::SEQ_DIV_MW;
      qti_pkg::SEQ_DIV_MW: if (div_done) state_d = qti_pkg::SEQ_DIV_MQ;
      qti_pkg::SEQ_DIV_MQ: if (div_done) state_d = qti_pkg::SEQ_DIV_MK;
      qti_pkg::SEQ_DIV_MK: if (div_done) state_d = qti_pkg::SEQ_IDLE;
      qti_pkg::SEQ_IDLE:   state_d = qti_pkg::SEQ_IDLE;
      default:             state_d = qti_pkg::SEQ_LOAD;
    endcase
    if (cfg_we_i) begin
      state_d = qti_pkg::SEQ_LOAD;
    end
  end

  always_comb begin
    div_run      = state_q inside {qti_pkg::SEQ_DIV_Q, qti_pkg::SEQ_DIV_MW,
                                   qti_pkg::SEQ_DIV_MQ, qti_pkg::SEQ_DIV_MK};
    div_done     = div_run && (cnt_q == 5'(qti_pkg::DIV_STEPS - 1));
    div_load     = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state_q)
      qti_pkg::SEQ_LOAD: begin
        div_load     = 1'b1;
        div_dividend = {14'b0, block_size_q};
        div_divisor  = {6'b0, weff_d};
      end
      qti_pkg::SEQ_DIV_Q: begin
        div_load     = div_done;
        div_dividend = 27'd8192;
        div_divisor  = {6'b0, weff_q};
      end
      qti_pkg::SEQ_DIV_MW: begin
        div_load     = div_done;
        div_dividend = 27'd8192;
        div_divisor  = q_q;
      end
      qti_pkg::SEQ_DIV_MQ: begin
        div_load     = div_done;
        div_dividend = 27'h4000000;
        div_divisor  = block_size_q;
      end
      default: begin
        div_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qti_pkg::SEQ_LOAD;
      cnt_q   <= '0;
      bad_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (div_load) begin
        cnt_q <= '0;
      end else if (div_run) begin
        cnt_q <= cnt_q + 5'd1;
      end
      if (state_q == qti_pkg::SEQ_LOAD) begin
        bad_q <= !slot.ok;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_load) begin
      rem_q <= '0;
      dq_q  <= div_dividend;
      dvs_q <= div_divisor;
    end else if (div_run) begin
      rem_q <= rem_step;
      dq_q  <= dq_step;
    end
    if (state_q == qti_pkg::SEQ_LOAD) begin
      weff_q <= weff_d;
      f1_q   <= qti_pkg::F1_ROM[slot.slot];
      f2_q   <= qti_pkg::F2_ROM[slot.slot];
    end
    if (div_done) begin
      case (state_q)
        qti_pkg::SEQ_DIV_Q:  q_q  <= dq_step[12:0];
        qti_pkg::SEQ_DIV_MW: mw_q <= dq_step[13:0];
        qti_pkg::SEQ_DIV_MQ: mq_q <= dq_step[13:0];
        default:             mk_q <= dq_step[20:0];
      endcase
    end
  end

  // request pipeline, stages 1..8, output register is stage 9
  logic [9:1] v_q, en;
  logic       accept, build_pending;
  qti_pkg::stage_ctl_t ctl_q [1:8];
  logic [12:0] idx_q [1:8];

  always_comb begin
    en[9] = !v_q[9] || !out_stall_i;
    for (int k = 8; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    build_pending = 1'b0;
    for (int k = 1; k <= 8; k++) begin
      build_pending = build_pending || (v_q[k] && ctl_q[k].func == qti_pkg::FUNC_BUILD);
    end
  end

  // hold reads until all pending table writes have landed
  assign in_stall_o = (state_q != qti_pkg::SEQ_IDLE) || !en[1] ||
                      (in_req_i.func == qti_pkg::FUNC_READ && build_pending);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= accept;
      for (int k = 2; k <= 9; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // build lane
  logic [22:0] s2_d, s2_q, u3_d, u3_q, u4_q;
  logic [40:0] p4_d, p4_q;
  logic [30:0] prod5;
  logic [13:0] r5;
  logic [12:0] t5_d, t5_q;
  logic [25:0] v6_d, v6_q, v7_q;
  logic [46:0] p7_d, p7_q;
  logic [33:0] prod8;
  logic [13:0] r8;
  logic [12:0] j8_d, j8_q;

  // read lane
  logic [26:0] p2r_d, p2r_q;
  logic [19:0] prod3;
  logic [7:0]  r3;
  logic        ge3;
  logic [7:0]  rw3_full;
  logic [6:0]  rw3_q;
  logic [12:0] qw3_d, qw3_q;
  logic [19:0] prod4;
  logic [13:0] a4_d, a4_q;
  logic        oor4_q, oor5_q;
  logic [12:0] rdata_f, rdata_r, xf6_d, xr6_d, xf6_q, xr6_q;
  logic [26:0] pf6_d, pr6_d, pf6_q, pr6_q;
  logic [25:0] dfix_f, dfix_r;
  logic [12:0] rqf7_q, rrf7_q, rqr7_q, rrr7_q;
  logic [19:0] prodf8, prodr8;
  logic [12:0] yf8_d, yr8_d, yf8_q, yr8_q;
  logic        tbl_we;
  qti_pkg::out_rsp_t out_d, out_q;

  // x mod q and x / q from a reciprocal estimate with one correction
  function automatic logic [25:0] deinter_fix(logic [12:0] x, logic [26:0] p,
                                               logic [12:0] q);
    logic [12:0] qe;
    logic [25:0] prod;
    logic [13:0] r;
    logic [13:0] rc;
    logic        ge;
    qe   = p[25:13];
    prod = qe * q;
    r    = {1'b0, x} - prod[13:0];
    ge   = (r >= {1'b0, q});
    rc   = r - {1'b0, q};
    return {qe + {12'b0, ge}, ge ? rc[12:0] : r[12:0]};
  endfunction

  always_comb begin
    s2_d  = f2_q * idx_q[1];
    p2r_d = idx_q[1] * mw_q;

    u3_d     = s2_q + {14'b0, f1_q};
    qw3_d    = p2r_q[25:13];
    prod3    = qw3_d * weff_q;
    r3       = idx_q[2][7:0] - prod3[7:0];
    ge3      = (r3 >= {1'b0, weff_q});
    rw3_full = ge3 ? (r3 - {1'b0, weff_q}) : r3;
    qw3_d    = qw3_d + {12'b0, ge3};

    p4_d  = u3_q * mk23;
    prod4 = rw3_q * q_q;
    a4_d  = prod4[13:0] + {1'b0, qw3_q};

    prod5 = p4_q[40:23] * block_size_q;
    r5    = u4_q[13:0] - prod5[13:0];
    t5_d  = (r5 >= {1'b0, block_size_q}) ? 13'(r5 - {1'b0, block_size_q}) : r5[12:0];

    v6_d  = t5_q * idx_q[5];
    xf6_d = oor5_q ? 13'd0 : rdata_f;
    xr6_d = oor5_q ? 13'd0 : rdata_r;
    pf6_d = xf6_d * mq_q;
    pr6_d = xr6_d * mq_q;

    p7_d   = v6_q * mk_q;
    dfix_f = deinter_fix(xf6_q, pf6_q, q_q);
    dfix_r = deinter_fix(xr6_q, pr6_q, q_q);

    prod8  = p7_q[46:26] * block_size_q;
    r8     = v7_q[13:0] - prod8[13:0];
    j8_d   = (r8 >= {1'b0, block_size_q}) ? 13'(r8 - {1'b0, block_size_q}) : r8[12:0];
    prodf8 = rrf7_q * weff_q;
    prodr8 = rrr7_q * weff_q;
    yf8_d  = prodf8[12:0] + rqf7_q;
    yr8_d  = prodr8[12:0] + rqr7_q;

    out_d = '0;
    if (bad_q) begin
      out_d.status = 1'b1;
    end else if (ctl_q[8].func == qti_pkg::FUNC_BUILD) begin
      out_d.reverse_index = idx_q[8];
      out_d.forward_index = ctl_q[8].oob ? 13'd0 : j8_q;
    end else if (!ctl_q[8].oob) begin
      out_d.forward_index = yf8_q;
      out_d.reverse_index = yr8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      ctl_q[1].func <= in_req_i.func;
      ctl_q[1].oob  <= (in_req_i.index >= block_size_q);
      idx_q[1]      <= in_req_i.index;
    end
    for (int k = 2; k <= 8; k++) begin
      if (en[k]) begin
        ctl_q[k] <= ctl_q[k-1];
        idx_q[k] <= idx_q[k-1];
      end
    end
    if (en[2]) begin
      s2_q  <= s2_d;
      p2r_q <= p2r_d;
    end
    if (en[3]) begin
      u3_q  <= u3_d;
      qw3_q <= qw3_d;
      rw3_q <= rw3_full[6:0];
    end
    if (en[4]) begin
      u4_q   <= u3_q;
      p4_q   <= p4_d;
      a4_q   <= a4_d;
      oor4_q <= (a4_d >= 14'(qti_pkg::MAX_BLOCK));
    end
    if (en[5]) begin
      t5_q   <= t5_d;
      oor5_q <= oor4_q;
    end
    if (en[6]) begin
      v6_q  <= v6_d;
      xf6_q <= xf6_d;
      xr6_q <= xr6_d;
      pf6_q <= pf6_d;
      pr6_q <= pr6_d;
    end
    if (en[7]) begin
      v7_q   <= v6_q;
      p7_q   <= p7_d;
      rqf7_q <= dfix_f[25:13];
      rrf7_q <= dfix_f[12:0];
      rqr7_q <= dfix_r[25:13];
      rrr7_q <= dfix_r[12:0];
    end
    if (en[8]) begin
      j8_q  <= j8_d;
      yf8_q <= yf8_d;
      yr8_q <= yr8_d;
    end
    if (en[9]) begin
      out_q <= out_d;
    end
  end

  // write both tables as a build request leaves stage 8
  assign tbl_we = v_q[8] && en[9] && ctl_q[8].func == qti_pkg::FUNC_BUILD &&
                  !ctl_q[8].oob && !bad_q;

  qti_ram #(.WIDTH(13), .DEPTH(qti_pkg::MAX_BLOCK)) u_forward_mem (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (idx_q[8]),
    .wdata_i (j8_q),
    .re_i    (en[5]),
    .raddr_i (a4_q[12:0]),
    .rdata_o (rdata_f)
  );

  qti_ram #(.WIDTH(13), .DEPTH(qti_pkg::MAX_BLOCK)) u_reverse_mem (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (j8_q),
    .wdata_i (idx_q[8]),
    .re_i    (en[5]),
    .raddr_i (a4_q[12:0]),
    .rdata_o (rdata_r)
  );

  assign out_valid_o = v_q[9];
  assign out_rsp_o   = out_q;

endmodule

FILE: sv/qti_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module qti_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 6144
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: sv/qti_checker.sv
// Port-level checks for the QPP turbo interleaver, bound to the top level.
// Uses qti_pkg types.
module qti_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_we_i,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input qti_pkg::in_req_t  in_req_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input qti_pkg::out_rsp_t out_rsp_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_req_i))
    else $error("stalled request changed or withdrawn");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("response dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_rsp_o))
    else $error("stalled response changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status |->
      out_rsp_o.forward_index == 13'd0 && out_rsp_o.reverse_index == 13'd0)
    else $error("error response carries nonzero indexes");

  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o)
    else $error("request taken while constants are recomputed");

endmodule

bind qpp_turbo_interleaver qti_checker u_qti_checker (.*);

FILE: verif/testbench.sv
// Self-checking testbench for qpp_turbo_interleaver: builds full QPP tables for a
// few block sizes and windows, mixes reads, rebuilds and out-of-range requests.
// Depends on qti_pkg and the interleaver RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Mirror of the interleaver tables and its two registers.
  class qpp_tables;
    logic [12:0]       blk_len;
    logic [6:0]        win;
    logic [12:0]       fwd_tab [qti_pkg::MAX_BLOCK];
    logic [12:0]       rev_tab [qti_pkg::MAX_BLOCK];
    qti_pkg::out_rsp_t pending_rsp [$];
    int                mismatches;

    function void set_reg(logic idx, logic [12:0] data);
      if (idx == qti_pkg::CFG_BLOCK_SIZE) blk_len = data;
      else win = data[6:0];
    endfunction

    // ROM slot of K, or -1 when K is not a legal code block size.
    function int lte_slot(int k);
      if (k < 40 || k > qti_pkg::MAX_BLOCK) return -1;
      if (k <= 512) return (k % 8 != 0) ? -1 : (k - 40) / 8;
      if (k <= 1024) return (k % 16 != 0) ? -1 : 59 + (k - 512) / 16;
      if (k <= 2048) return (k % 32 != 0) ? -1 : 91 + (k - 1024) / 32;
      return (k % 64 != 0) ? -1 : 123 + (k - 2048) / 64;
    endfunction

    function logic [12:0] win_lookup(bit rev, int i, int k, int w);
      int q, a, x;
      q = k / w;
      a = (i % w) * q + i / w;
      x = rev ? rev_tab[a] : fwd_tab[a];
      return 13'((x % q) * w + x / q);
    endfunction

    function void note_request(qti_pkg::in_req_t req);
      qti_pkg::out_rsp_t rsp;
      int                k, i, s, w;
      longint            v;
      k = blk_len;
      i = req.index;
      s = lte_slot(k);
      rsp = '0;
      if (s < 0) begin
        rsp.status = 1'b1;
      end else if (req.func == qti_pkg::FUNC_BUILD) begin
        rsp.reverse_index = req.index;
        if (i < k) begin
          v = longint'(qti_pkg::F1_ROM[s]) * i + longint'(qti_pkg::F2_ROM[s]) * i * i;
          rsp.forward_index = 13'(v % k);
          fwd_tab[i] = rsp.forward_index;
          rev_tab[rsp.forward_index] = req.index;
        end
      end else if (i < k) begin
        w = win;
        if (w == 0 || w > k) w = 1;
        rsp.forward_index = win_lookup(1'b0, i, k, w);
        rsp.reverse_index = win_lookup(1'b1, i, k, w);
      end
      pending_rsp.push_back(rsp);
    endfunction

    function void check_response(qti_pkg::out_rsp_t got);
      qti_pkg::out_rsp_t want;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", got);
        return;
      end
      want = pending_rsp.pop_front();
      if (got.forward_index !== want.forward_index ||
          got.reverse_index !== want.reverse_index || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction

    function int pending();
      return pending_rsp.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_idx_i = 1'b0;
  logic [12:0]       cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  qti_pkg::in_req_t  in_req_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  qti_pkg::out_rsp_t out_rsp_o;

  qpp_tables model = new();
  int  send_idle_pct = 22;
  int  recv_idle_pct = 49;
  int  hold_left = 0;
  longint cycles = 0;

  qpp_turbo_interleaver dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 200_000) begin
      $display("[qpp_turbo_interleaver] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i) model.check_response(out_rsp_o);

  // Long hold-offs take priority over random stalling.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send(logic func, logic [12:0] index);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= '{func: func, index: index};
    do @(posedge clk_i); while (in_stall_o);
    model.note_request(in_req_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (model.pending() != 0) @(posedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [12:0] data);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    model.set_reg(idx, data);
  endtask

  // Build every index below K in shuffled order, with some out-of-range noise.
  task automatic build_all();
    int order[];
    int k, j, t;
    k = model.blk_len;
    order = new[k];
    foreach (order[n]) order[n] = n;
    for (int n = k - 1; n > 0; n--) begin
      j = $urandom_range(n);
      t = order[n]; order[n] = order[j]; order[j] = t;
    end
    foreach (order[n]) begin
      if ($urandom_range(19) == 0) begin
        send(qti_pkg::FUNC_BUILD, 13'($urandom_range(8191, k)));
      end
      send(qti_pkg::FUNC_BUILD, 13'(order[n]));
    end
  endtask

  task automatic mixed_traffic(int count);
    int k, r;
    k = model.blk_len;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 70) send(qti_pkg::FUNC_READ, 13'($urandom_range(k - 1)));
      else if (r < 85) send(qti_pkg::FUNC_BUILD, 13'($urandom_range(k - 1)));
      else send(1'($urandom), 13'($urandom_range(8191, k)));
    end
  endtask

  task automatic run_phase(int k, logic [12:0] w, int count);
    write_reg(qti_pkg::CFG_BLOCK_SIZE, 13'(k));
    write_reg(qti_pkg::CFG_WINDOW_SIZE, w);
    build_all();
    mixed_traffic(count);
  endtask

  // Large blocks: scattered builds only, so no table is read.
  task automatic build_sample(int k, int count);
    write_reg(qti_pkg::CFG_BLOCK_SIZE, 13'(k));
    send(qti_pkg::FUNC_BUILD, 13'(k - 1));
    repeat (count) send(qti_pkg::FUNC_BUILD, 13'($urandom_range(k - 1)));
    send(qti_pkg::FUNC_BUILD, 13'($urandom_range(8191, k)));
  endtask

  initial begin
    model.blk_len = 13'd40;
    model.win = 7'd1;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: K = 40, w = 1.
    send(qti_pkg::FUNC_BUILD, 13'h1FFF);
    send(qti_pkg::FUNC_READ, 13'h1FFF);
    send(qti_pkg::FUNC_BUILD, 13'd40);
    send(qti_pkg::FUNC_READ, 13'd40);
    build_all();
    send(qti_pkg::FUNC_READ, 13'd0);
    send(qti_pkg::FUNC_READ, 13'd39);
    write_reg(qti_pkg::CFG_WINDOW_SIZE, 13'd0);
    send(qti_pkg::FUNC_READ, 13'd5);
    write_reg(qti_pkg::CFG_WINDOW_SIZE, 13'd40);
    send(qti_pkg::FUNC_READ, 13'd0);
    send(qti_pkg::FUNC_READ, 13'd39);
    write_reg(qti_pkg::CFG_WINDOW_SIZE, 13'd7);
    send(qti_pkg::FUNC_READ, 13'd38);
    send(qti_pkg::FUNC_READ, 13'd13);
    // Illegal block sizes answer with an error status only.
    write_reg(qti_pkg::CFG_BLOCK_SIZE, 13'd41);
    send(qti_pkg::FUNC_BUILD, 13'd0);
    send(qti_pkg::FUNC_READ, 13'd0);
    write_reg(qti_pkg::CFG_BLOCK_SIZE, 13'd0);
    send(qti_pkg::FUNC_BUILD, 13'h1FFF);
    write_reg(qti_pkg::CFG_BLOCK_SIZE, 13'h1FFF);
    send(qti_pkg::FUNC_READ, 13'd3);
    write_reg(qti_pkg::CFG_BLOCK_SIZE, 13'd6145);
    repeat (40) send(1'($urandom), 13'($urandom));

    run_phase(104, 13'd8, 80);

    send_idle_pct = 49;
    recv_idle_pct = 22;
    run_phase(248, 13'd7, 80);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(64, 13'd3, 60);
    // Hold the output off long enough to back up the pipeline.
    hold_left = 400;
    mixed_traffic(120);
    drain();
    mixed_traffic(40);

    build_sample(512, 25);
    build_sample(1056, 25);
    build_sample(2112, 25);
    build_sample(6144, 25);

    drain();
    if (model.mismatches == 0 && model.pending() == 0) begin
      $display("[qpp_turbo_interleaver] OK");
    end else begin
      $display("[qpp_turbo_interleaver] ERROR");
    end
    $finish;
  end
endmodule

FILE: filelist.f
sv/qti_pkg.sv
sv/qti_ram.sv
sv/qpp_turbo_interleaver.sv
sv/qti_checker.sv
verif/testbench.sv
